// File: rtl/f2b90_pkg.sv
`default_nettype none

package f2b90_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int COUNT_W    = 4;
    localparam int FRAC_W     = 23;
    localparam int CODE_W     = 8;
    localparam int DIGIT_W    = 7;
    localparam int Q90_W      = 17;
    localparam int Q8100_W    = 11;
    localparam int Q729K_W    = 4;

    localparam int VALUES_PER_LINE_DEF = 15;

    // Magnitude limits: the binary32 patterns nearest 1e28 and 1e-28
    localparam logic [30:0] BIG_MAG   = 31'h6E013F39;
    localparam logic [30:0] SMALL_MAG = 31'h10FD87B6;

    localparam logic [CODE_W-1:0] EXP_CODE_OFFSET = 8'd2;
    localparam logic [CODE_W-1:0] BASE            = 8'd90;
    localparam logic [CODE_W-1:0] TWO_BASE        = 8'd180;

    // Reciprocals: floor(x / d) == (x * RECIP) >> SHIFT for any 23-bit x
    localparam logic [23:0] RECIP_90    = 24'd11930465;
    localparam int          SHIFT_90    = 30;
    localparam logic [23:0] RECIP_8100  = 24'd8483887;
    localparam int          SHIFT_8100  = 36;
    localparam logic [23:0] RECIP_729K  = 24'd6032986;
    localparam int          SHIFT_729K  = 42;
    localparam int          PROD_W      = FRAC_W + 24;

    localparam logic [DIGIT_W-1:0] ZERO_TOP_DIGIT = 7'd80;
    localparam logic [DIGIT_W-1:0] SIGN_OFFSET    = 7'd40;
    localparam logic [DIGIT_W-1:0] HIGH_WEIGHT    = 7'd12;
    localparam logic [CHAR_W-1:0]  CHAR_OFFSET    = 7'd33;
    localparam logic [CHAR_W-1:0]  SKIP_CHAR_A    = 7'd94;
    localparam logic [CHAR_W-1:0]  SKIP_CHAR_B    = 7'd123;

    // Quotient stage contents, one encoded value
    typedef struct packed {
        logic                  sign;
        logic                  zero;
        logic                  last;
        logic [CODE_W-1:0]     code;
        logic [FRAC_W-1:0]     frac;
        logic [Q90_W-1:0]      q90;
        logic [Q8100_W-1:0]    q8100;
        logic [Q729K_W-1:0]    q729k;
    } quot_t;

    typedef struct packed {
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic [CHAR_W-1:0] third_char;
        logic [CHAR_W-1:0] fourth_char;
        logic [CHAR_W-1:0] fifth_char;
        logic              line_end;
    } chars_t;

    // Shift a digit into the printable range, stepping over two reserved codes
    function automatic logic [CHAR_W-1:0] map_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = d + CHAR_OFFSET;
        if (c >= SKIP_CHAR_A)
            c = c + 7'd1;
        if (c >= SKIP_CHAR_B)
            c = c + 7'd1;
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/f2b90_if.sv
`default_nettype none

interface f2b90_in_if import f2b90_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_bits;
    logic               last_of_array;

    modport source (output valid, value_bits, last_of_array, input ready);
    modport sink   (input valid, value_bits, last_of_array, output ready);
endinterface

interface f2b90_out_if import f2b90_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] second_char;
    logic [CHAR_W-1:0] third_char;
    logic [CHAR_W-1:0] fourth_char;
    logic [CHAR_W-1:0] fifth_char;
    logic              line_end;

    modport source (output valid, first_char, second_char, third_char, fourth_char,
                    fifth_char, line_end, input ready);
    modport sink   (input valid, first_char, second_char, third_char, fourth_char,
                    fifth_char, line_end, output ready);
endinterface

`default_nettype wire

// File: rtl/f2b90_front.sv
`default_nettype none

module f2b90_front import f2b90_pkg::*;
(
    input  wire logic [VALUE_W-1:0] value_bits,
    input  wire logic               last_of_array,
    output quot_t                   quot
);

    logic [30:0]       mag;
    logic [30:0]       mag_clamped;
    logic [FRAC_W-1:0] frac;
    logic [PROD_W-1:0] prod_90;
    logic [PROD_W-1:0] prod_8100;
    logic [PROD_W-1:0] prod_729k;

    assign mag = value_bits[30:0];

    always_comb
    begin
        mag_clamped = mag;
        if (mag > BIG_MAG)
            mag_clamped = BIG_MAG;
        if (mag < SMALL_MAG)
            mag_clamped = SMALL_MAG;
    end

    assign frac = mag_clamped[FRAC_W-1:0];

    // Three independent quotients of the fraction; digits come from them next stage
    assign prod_90   = PROD_W'(frac) * PROD_W'(RECIP_90);
    assign prod_8100 = PROD_W'(frac) * PROD_W'(RECIP_8100);
    assign prod_729k = PROD_W'(frac) * PROD_W'(RECIP_729K);

    always_comb
    begin
        quot.sign  = value_bits[31];
        quot.zero  = (mag == 31'd0);
        quot.last  = last_of_array;
        quot.code  = mag_clamped[30:23] + EXP_CODE_OFFSET;
        quot.frac  = frac;
        quot.q90   = prod_90[SHIFT_90 +: Q90_W];
        quot.q8100 = prod_8100[SHIFT_8100 +: Q8100_W];
        quot.q729k = prod_729k[SHIFT_729K +: Q729K_W];
    end

endmodule

`default_nettype wire

// File: rtl/f2b90_back.sv
`default_nettype none

module f2b90_back import f2b90_pkg::*;
#(
    parameter int VALUES_PER_LINE = VALUES_PER_LINE_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire quot_t quot,
    output chars_t    chars
);

    logic [COUNT_W-1:0]  values_on_line_reg;
    logic [COUNT_W-1:0]  values_on_line_next;
    logic [COUNT_W:0]    count_inc;
    logic                eol;

    logic [FRAC_W:0]     q90_x;
    logic [FRAC_W:0]     d0_full;
    logic [Q90_W:0]      q8100_x;
    logic [Q90_W:0]      d1_full;
    logic [Q8100_W:0]    q729k_x;
    logic [Q8100_W:0]    d2_full;
    logic [1:0]          high;
    logic [CODE_W-1:0]   code_low;
    logic [DIGIT_W-1:0]  top_digit;
    logic [DIGIT_W-1:0]  dig0, dig1, dig2, dig3, dig4;

    assign q90_x   = (FRAC_W+1)'(quot.q90) * (FRAC_W+1)'(BASE);
    assign d0_full = (FRAC_W+1)'(quot.frac) - q90_x;
    assign q8100_x = (Q90_W+1)'(quot.q8100) * (Q90_W+1)'(BASE);
    assign d1_full = (Q90_W+1)'(quot.q90) - q8100_x;
    assign q729k_x = (Q8100_W+1)'(quot.q729k) * (Q8100_W+1)'(BASE);
    assign d2_full = (Q8100_W+1)'(quot.q8100) - q729k_x;

    always_comb
    begin
        if (quot.code >= TWO_BASE)
        begin
            high     = 2'd2;
            code_low = quot.code - TWO_BASE;
        end
        else if (quot.code >= BASE)
        begin
            high     = 2'd1;
            code_low = quot.code - BASE;
        end
        else
        begin
            high     = 2'd0;
            code_low = quot.code;
        end
    end

    always_comb
    begin
        top_digit = DIGIT_W'(quot.q729k) + DIGIT_W'(high) * HIGH_WEIGHT;
        if (quot.sign)
            top_digit = top_digit + SIGN_OFFSET;

        if (quot.zero)
        begin
            dig0 = '0;
            dig1 = '0;
            dig2 = '0;
            dig3 = '0;
            dig4 = ZERO_TOP_DIGIT;
        end
        else
        begin
            dig0 = d0_full[DIGIT_W-1:0];
            dig1 = d1_full[DIGIT_W-1:0];
            dig2 = d2_full[DIGIT_W-1:0];
            dig3 = code_low[DIGIT_W-1:0];
            dig4 = top_digit;
        end
    end

    assign count_inc = (COUNT_W+1)'(values_on_line_reg) + (COUNT_W+1)'(1);
    assign eol       = quot.last || (count_inc >= (COUNT_W+1)'(VALUES_PER_LINE));

    always_comb
    begin
        values_on_line_next = values_on_line_reg;
        if (advance)
            values_on_line_next = eol ? '0 : count_inc[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            values_on_line_reg <= '0;
        else
            values_on_line_reg <= values_on_line_next;
    end

    always_comb
    begin
        chars.first_char  = map_char(dig0);
        chars.second_char = map_char(dig1);
        chars.third_char  = map_char(dig2);
        chars.fourth_char = map_char(dig3);
        chars.fifth_char  = map_char(dig4);
        chars.line_end    = eol;
    end

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_W+1)'(values_on_line_reg) < (COUNT_W+1)'(VALUES_PER_LINE))
        else $error("line counter reached line length");

    a_count_clears_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
        advance && eol |=> values_on_line_reg == '0)
        else $error("line counter not cleared after line end");

    a_count_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(values_on_line_reg))
        else $error("line counter moved without a transaction");

endmodule

`default_nettype wire

// File: rtl/float_to_base90_text_encoder.sv
// Encodes one IEEE-754 binary32 value per transaction into five printable base-90
// characters and a line-end flag. Throughput is one value per clock cycle while the
// output is not stalled. Each value passes through three register stages in order:
// input register (loaded at acceptance), quotient register (fraction divided by 90,
// 8100 and 729000 through reciprocal multipliers) and result register (digits and
// character mapping). Backpressure on the output stalls the stages behind it; empty
// stages keep accepting. Zero of either sign encodes as 33,33,33,33,114.
// Line end is raised after every VALUES_PER_LINE values and on any value marked last
// of its array.
`default_nettype none

module float_to_base90_text_encoder import f2b90_pkg::*;
#(
    parameter int VALUES_PER_LINE = VALUES_PER_LINE_DEF
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    f2b90_in_if.sink    sample,
    f2b90_out_if.source text
);

    logic               in_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic               mid_valid_reg;
    quot_t              quot_reg;
    quot_t              quot_next;
    logic               out_valid_reg;
    chars_t             chars_reg;
    chars_t             chars_next;

    logic out_free;
    logic mid_free;
    logic in_free;
    logic mid_adv;
    logic in_adv;

    assign out_free = !out_valid_reg || text.ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_free  = !in_valid_reg || mid_free;
    assign mid_adv  = mid_valid_reg && out_free;
    assign in_adv   = in_valid_reg && mid_free;

    assign sample.ready = in_free;

    f2b90_front u_front (
        .value_bits    (value_reg),
        .last_of_array (last_reg),
        .quot          (quot_next)
    );

    f2b90_back #(
        .VALUES_PER_LINE (VALUES_PER_LINE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (mid_adv),
        .quot    (quot_reg),
        .chars   (chars_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= sample.valid;
            if (mid_free)
                mid_valid_reg <= in_valid_reg;
            if (out_free)
                out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && in_free)
        begin
            value_reg <= sample.value_bits;
            last_reg  <= sample.last_of_array;
        end
        if (in_adv)
            quot_reg <= quot_next;
        if (mid_adv)
            chars_reg <= chars_next;
    end

    assign text.valid       = out_valid_reg;
    assign text.first_char  = chars_reg.first_char;
    assign text.second_char = chars_reg.second_char;
    assign text.third_char  = chars_reg.third_char;
    assign text.fourth_char = chars_reg.fourth_char;
    assign text.fifth_char  = chars_reg.fifth_char;
    assign text.line_end    = chars_reg.line_end;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample.ready)
        else $error("input blocked while result stage is empty");

    a_input_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_adv |=> in_valid_reg && $stable(value_reg))
        else $error("input stage lost a stalled transaction");

    a_quot_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && !mid_adv |=> mid_valid_reg && $stable(quot_reg))
        else $error("quotient stage lost a stalled transaction");

endmodule

`default_nettype wire

// File: dv/f2b90_char_check.sv
`timescale 1ns / 1ps

module f2b90_char_check import f2b90_pkg::*;
#(
    parameter int VALUES_PER_LINE = VALUES_PER_LINE_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    f2b90_in_if   sample,
    f2b90_out_if  text,
    output int    mismatch_count,
    output int    chars_due_count
);

    chars_t           chars_due [$];
    logic [COUNT_W-1:0] values_on_line;

    initial
    begin
        mismatch_count  = 0;
        chars_due_count = 0;
        values_on_line  = '0;
    end

    function automatic logic [CHAR_W-1:0] to_printable(input int unsigned digit);
        int unsigned c;
        c = digit + CHAR_OFFSET;
        if (c >= SKIP_CHAR_A)
            c = c + 1;
        if (c >= SKIP_CHAR_B)
            c = c + 1;
        return c[CHAR_W-1:0];
    endfunction

    // Characters for one value; line_end is filled in by the caller
    function automatic chars_t encode_chars(input logic [VALUE_W-1:0] bits);
        chars_t      enc;
        logic [30:0] mag;
        int unsigned code;
        int unsigned frac;
        int unsigned d0, d1, d2, d3, d4;
        mag = bits[30:0];
        if (mag == '0)
        begin
            // sign of a zero is dropped
            d0 = 0;
            d1 = 0;
            d2 = 0;
            d3 = 0;
            d4 = ZERO_TOP_DIGIT;
        end
        else
        begin
            if (mag > BIG_MAG)
                mag = BIG_MAG;
            if (mag < SMALL_MAG)
                mag = SMALL_MAG;
            code = int'(mag[30:23]) + EXP_CODE_OFFSET;
            frac = int'(mag[22:0]);
            d3 = code % 90;
            d4 = frac / 729000;
            d2 = (frac % 729000) / 8100;
            d1 = (frac % 8100) / 90;
            d0 = frac % 90;
            d4 = d4 + (code / 90) * HIGH_WEIGHT;
            if (bits[31])
                d4 = d4 + SIGN_OFFSET;
        end
        enc.first_char  = to_printable(d0);
        enc.second_char = to_printable(d1);
        enc.third_char  = to_printable(d2);
        enc.fourth_char = to_printable(d3);
        enc.fifth_char  = to_printable(d4);
        enc.line_end    = 1'b0;
        return enc;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        chars_t      want;
        int unsigned count_next;
        if (!rst_n)
        begin
            values_on_line = '0;
        end
        else
        begin
            // compare first: a result leaving now always belongs to an older transaction
            if (text.valid && text.ready)
            begin
                if (chars_due.size() == 0)
                begin
                    flag_mismatch("unexpected transaction", text.first_char, 0);
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (text.first_char != want.first_char)
                        flag_mismatch("first_char", text.first_char, want.first_char);
                    if (text.second_char != want.second_char)
                        flag_mismatch("second_char", text.second_char, want.second_char);
                    if (text.third_char != want.third_char)
                        flag_mismatch("third_char", text.third_char, want.third_char);
                    if (text.fourth_char != want.fourth_char)
                        flag_mismatch("fourth_char", text.fourth_char, want.fourth_char);
                    if (text.fifth_char != want.fifth_char)
                        flag_mismatch("fifth_char", text.fifth_char, want.fifth_char);
                    if (text.line_end != want.line_end)
                        flag_mismatch("line_end", text.line_end, want.line_end);
                end
            end
            if (sample.valid && sample.ready)
            begin
                want = encode_chars(sample.value_bits);
                count_next = int'(values_on_line) + 1;
                want.line_end = sample.last_of_array || (count_next >= VALUES_PER_LINE);
                values_on_line = want.line_end ? '0 : count_next[COUNT_W-1:0];
                chars_due.push_back(want);
            end
            chars_due_count = chars_due.size();
        end
    end

endmodule

// File: dv/tb_float_to_base90_text_encoder.sv
`timescale 1ns / 1ps

module tb_float_to_base90_text_encoder;
    import f2b90_pkg::*;

    localparam int RANDOM_VALUES = 1800;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DIRECTED_N    = 24;

    // {last_of_array, value_bits}
    localparam logic [32:0] DIRECTED [DIRECTED_N] = '{
        {1'b0, 32'h00000000},   // positive zero
        {1'b0, 32'h80000000},   // negative zero
        {1'b0, 32'h3F800000},   // 1.0
        {1'b0, 32'hBF800000},
        {1'b0, 32'h3F000000},   // powers of two below one
        {1'b0, 32'h3E800000},
        {1'b0, 32'h00000001},   // subnormals
        {1'b0, 32'h807FFFFF},
        {1'b0, 32'h7F800000},   // infinities
        {1'b0, 32'hFF800000},
        {1'b0, 32'h7FC00000},   // NaN, both signs
        {1'b0, 32'hFFFFFFFF},
        {1'b0, 32'h6E013F39},   // upper clamp and just above
        {1'b0, 32'h6E013F3A},
        {1'b1, 32'h10FD87B6},   // fifteenth value and last together
        {1'b0, 32'h90FD87B5},   // just below lower clamp
        {1'b0, 32'h3FFFFFFF},   // full fraction
        {1'b0, 32'h3F8B1FA7},   // fraction digit carries
        {1'b0, 32'h3F8B1FA8},
        {1'b1, 32'h3F801FA3},
        {1'b0, 32'h2B80005A},   // exponent code 89 / 90
        {1'b0, 32'hAC000059},
        {1'b1, 32'h58800000},   // exponent code 179 / 180
        {1'b1, 32'h59000000}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic out_ready = 1'b0;
    int   send_idle = 33;
    int   recv_idle = 74;
    int   cycle_count = 0;
    int   mismatch_count;
    int   chars_due_count;

    f2b90_in_if  sample ();
    f2b90_out_if text ();

    assign text.ready = out_ready;

    float_to_base90_text_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample),
        .text  (text)
    );

    f2b90_char_check char_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .text           (text),
        .mismatch_count (mismatch_count),
        .chars_due_count(chars_due_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [VALUE_W-1:0] pick_value();
        logic        sign;
        logic [7:0]  expo;
        logic [30:0] mag;
        int          kind;
        sign = 1'($urandom_range(1));
        kind = $urandom_range(9);
        case (kind)
            0: return $urandom;
            1: return {sign, 31'h0};
            2: expo = 8'($urandom_range(0, 33));
            3: expo = 8'($urandom_range(220, 255));
            4:
            begin
                mag = $urandom_range(1) ? BIG_MAG : SMALL_MAG;
                mag = 31'(mag + $urandom_range(4) - 2);
                return {sign, mag};
            end
            5: return {sign, 8'($urandom_range(1, 254)), 23'h0};
            default: expo = 8'($urandom_range(33, 220));
        endcase
        return {sign, expo, 23'($urandom)};
    endfunction

    // Hold the transaction until accepted, then return at the next falling edge
    task automatic send_value(input logic [VALUE_W-1:0] bits, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            sample.valid      <= 1'b0;
            sample.value_bits <= $urandom;
            @(negedge clk);
        end
        sample.valid         <= 1'b1;
        sample.value_bits    <= bits;
        sample.last_of_array <= last;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sample.valid         <= 1'b0;
        sample.value_bits    <= '0;
        sample.last_of_array <= 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_value(DIRECTED[i][31:0], DIRECTED[i][32]);

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == RANDOM_VALUES / 3)
            begin
                send_idle = 74;
                recv_idle = 33;
            end
            else if (i == 2 * RANDOM_VALUES / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_value(pick_value(), $urandom_range(9) == 0);
        end
        sample.valid <= 1'b0;

        wait (chars_due_count == 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: float_to_base90_text_encoder.f
rtl/f2b90_pkg.sv
rtl/f2b90_if.sv
rtl/f2b90_front.sv
rtl/f2b90_back.sv
rtl/float_to_base90_text_encoder.sv
dv/f2b90_char_check.sv
dv/tb_float_to_base90_text_encoder.sv
